[rtl/scn_pkg.sv]
package scn_pkg;

   localparam int unsigned NORM_MAX = 65535;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned NORM_W  = 16;
   localparam int unsigned SPAN_W  = 16;
   localparam int unsigned DB_W    = 31;
   localparam int unsigned PROD_W  = DATA_W + NORM_W;
   localparam int unsigned NUM_W   = PROD_W + 2;
   localparam int unsigned DIV_W   = DATA_W + 2;
   localparam int unsigned QBITS_W = DATA_W + 1;
   localparam int unsigned CNT_W   = 6;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 88;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_MINIMUM   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAXIMUM   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEADBAND  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SMOOTHING = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT    = 3'd4;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_FORCE  = 1'b1;

   // one division job: partial remainder preload, dividend bits MSB first
   typedef struct packed {
      logic [DIV_W-1:0]   rem_init;
      logic [QBITS_W-1:0] bits;
      logic [CNT_W-1:0]   count;
      logic [DIV_W-1:0]   divisor;
   } div_cmd_type;

endpackage

[rtl/scn_div.sv]
module scn_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  scn_pkg::div_cmd_type         cmd,
   output logic                         done,
   output logic [scn_pkg::QBITS_W-1:0]  quotient
);
   import scn_pkg::*;

   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [QBITS_W-1:0] bits_ff, bits_in;
   logic [QBITS_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]   divisor_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DIV_W:0] trial;
   logic           fits;

   // one restoring step per cycle
   assign trial = {rem_ff, bits_ff[QBITS_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = cmd.rem_init;
         bits_in = cmd.bits;
         quo_in  = '0;
         cnt_in  = cmd.count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_W'(trial - {1'b0, divisor_ff}) : trial[DIV_W-1:0];
         bits_in = {bits_ff[QBITS_W-2:0], 1'b0};
         quo_in  = {quo_ff[QBITS_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      if (start) begin
         divisor_ff <= cmd.divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/smoothed_control_normalizer.sv]
// Smoothed control normalizer: turns timestamped Q16.16 sensor samples into
// a 16-bit normalized control position through a time-weighted exponential
// filter, a deadband gate, clamping, optional inversion and rounding.
// Channels: req_ carries one item (mode in tuser; sample, time_ms,
// forced_value in tdata), rsp_ returns exactly one result item per request.
// csr_ writes the five configuration registers; write only while idle.
// A filtered sample passes twice through the one shared restoring divider,
// which runs 33 steps for the filter step and 17 steps for the position.
// Seeding or unfiltered samples skip the first division; a suppressed
// sample skips the second; a force item skips both divisions. One item is
// in work at a time; req_tready is high only while the sequencer is idle,
// so the next item is taken after the result reaches the output register.
// The result sits in an output register: a new item may be accepted while
// it waits, and the sequencer holds its last step until the receiver takes
// the previous result.
// Reset (synchronous, active high) clears filter state, the generation
// counter and the output, and returns the registers to their defaults.
module smoothed_control_normalizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [scn_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample, time_ms, forced_value
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // normalized, value_valid, changed, suppressed, generation, filtered, zero pad
   output logic [scn_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [scn_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [scn_pkg::DATA_W-1:0]         csr_wdata
);
   import scn_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FILT  = 4'd1;
   localparam logic [3:0] ST_FMUL  = 4'd2;
   localparam logic [3:0] ST_FGO   = 4'd3;
   localparam logic [3:0] ST_FWAIT = 4'd4;
   localparam logic [3:0] ST_GATE  = 4'd5;
   localparam logic [3:0] ST_NMUL  = 4'd6;
   localparam logic [3:0] ST_NGO   = 4'd7;
   localparam logic [3:0] ST_NWAIT = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   // configuration
   logic signed [DATA_W-1:0] min_ff, max_ff;
   logic [DB_W-1:0]          deadband_ff;
   logic [SPAN_W-1:0]        span_ff;
   logic                     invert_ff;

   // item
   logic                     mode_ff;
   logic signed [DATA_W-1:0] sample_ff;
   logic [DATA_W-1:0]        now_ff;
   logic [NORM_W-1:0]        forced_ff;

   // control state
   logic [3:0]               state_ff, state_in;
   logic                     seeded_ff;
   logic signed [DATA_W-1:0] filter_ff;
   logic signed [DATA_W-1:0] published_ff;
   logic [DATA_W-1:0]        last_time_ff;
   logic                     has_out_ff;
   logic [NORM_W-1:0]        level_ff;
   logic [DATA_W-1:0]        gen_ff;
   logic                     changed_ff, suppressed_ff;

   // datapath scratch
   logic [DATA_W-1:0]        mag_ff;
   logic                     neg_ff;
   logic [SPAN_W-1:0]        elapsed_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [DATA_W-1:0]        p_ff, range_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   // divider
   div_cmd_type              div_cmd;
   logic                     div_start, div_done;
   logic [QBITS_W-1:0]       div_q;

   // combinational helpers
   logic signed [DATA_W:0]   diff;
   logic [DATA_W-1:0]        elapsed_raw;
   logic [DATA_W-1:0]        elapsed;
   logic                     direct;
   logic signed [DATA_W:0]   gap_s;
   logic [DATA_W:0]          gap;
   logic                     suppress;
   logic signed [DATA_W:0]   range_s, offset_s;
   logic                     range_pos, le_min, ge_max;
   logic [DATA_W-1:0]        rng, p_raw;
   logic [DATA_W-1:0]        mul_a;
   logic [NORM_W-1:0]        mul_b;
   logic [NUM_W-1:0]         num;
   logic [NORM_W-1:0]        take_v;
   logic                     take_en, take_chg;

   scn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_tready = (state_ff == ST_IDLE);

   // filter step decisions
   assign diff        = (DATA_W+1)'(sample_ff) - (DATA_W+1)'(filter_ff);
   assign elapsed_raw = now_ff - last_time_ff;
   assign elapsed     = (elapsed_raw == '0) ? DATA_W'(1) : elapsed_raw;
   assign direct      = !seeded_ff || (span_ff == '0) ||
                        (elapsed >= DATA_W'(span_ff));

   // deadband gate
   assign gap_s    = (DATA_W+1)'(filter_ff) - (DATA_W+1)'(published_ff);
   assign gap      = gap_s[DATA_W] ? (DATA_W+1)'(-gap_s) : gap_s;
   assign suppress = has_out_ff && (deadband_ff != '0) &&
                     (gap < (DATA_W+1)'(deadband_ff));

   // clamp and offset
   assign range_s   = (DATA_W+1)'(max_ff) - (DATA_W+1)'(min_ff);
   assign range_pos = !range_s[DATA_W] && (range_s != '0);
   assign le_min    = filter_ff <= min_ff;
   assign ge_max    = filter_ff >= max_ff;
   assign offset_s  = (DATA_W+1)'(filter_ff) - (DATA_W+1)'(min_ff);
   assign rng       = range_pos ? range_s[DATA_W-1:0] : DATA_W'(1);

   always_comb begin
      if (!range_pos) begin
         p_raw = le_min ? '0 : DATA_W'(1);
      end else if (le_min) begin
         p_raw = '0;
      end else if (ge_max) begin
         p_raw = rng;
      end else begin
         p_raw = offset_s[DATA_W-1:0];
      end
   end

   // shared multiplier operands
   assign mul_a = (state_ff == ST_NMUL) ? p_ff : mag_ff;
   assign mul_b = (state_ff == ST_NMUL) ? NORM_W'(NORM_MAX) : elapsed_ff;

   // rounded quotient: (2*prod + d) / (2*d)
   always_comb begin
      div_cmd = '0;
      if (state_ff == ST_NGO) begin
         num = {1'b0, prod_ff, 1'b0} + NUM_W'(range_ff);
         div_cmd.rem_init = DIV_W'(num[NUM_W-1:17]);
         div_cmd.bits     = {num[16:0], 16'b0};
         div_cmd.count    = CNT_W'(17);
         div_cmd.divisor  = {1'b0, range_ff, 1'b0};
      end else begin
         num = {1'b0, prod_ff, 1'b0} + NUM_W'(span_ff);
         div_cmd.rem_init = DIV_W'(num[NUM_W-1:QBITS_W]);
         div_cmd.bits     = num[QBITS_W-1:0];
         div_cmd.count    = CNT_W'(QBITS_W);
         div_cmd.divisor  = DIV_W'({span_ff, 1'b0});
      end
   end

   assign div_start = (state_ff == ST_FGO) || (state_ff == ST_NGO);

   // value update shared by force and publish
   assign take_v   = (state_ff == ST_FILT) ? forced_ff : div_q[NORM_W-1:0];
   assign take_en  = ((state_ff == ST_FILT) && (mode_ff == MODE_FORCE)) ||
                     ((state_ff == ST_NWAIT) && div_done);
   assign take_chg = !has_out_ff || (level_ff != take_v);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_FILT;
         ST_FILT: begin
            if (mode_ff == MODE_FORCE) begin
               state_in = ST_OUT;
            end else if (direct) begin
               state_in = ST_GATE;
            end else begin
               state_in = ST_FMUL;
            end
         end
         ST_FMUL:  state_in = ST_FGO;
         ST_FGO:   state_in = ST_FWAIT;
         ST_FWAIT: if (div_done) state_in = ST_GATE;
         ST_GATE:  state_in = suppress ? ST_OUT : ST_NMUL;
         ST_NMUL:  state_in = ST_NGO;
         ST_NGO:   state_in = ST_NWAIT;
         ST_NWAIT: if (div_done) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_ff        <= '0;
         max_ff        <= DATA_W'(65536);
         deadband_ff   <= '0;
         span_ff       <= '0;
         invert_ff     <= 1'b0;
         seeded_ff     <= 1'b0;
         filter_ff     <= '0;
         published_ff  <= '0;
         last_time_ff  <= '0;
         has_out_ff    <= 1'b0;
         level_ff      <= '0;
         gen_ff        <= '0;
         changed_ff    <= 1'b0;
         suppressed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_addr)
               CSR_MINIMUM:   min_ff      <= csr_wdata;
               CSR_MAXIMUM:   max_ff      <= csr_wdata;
               CSR_DEADBAND:  deadband_ff <= csr_wdata[DB_W-1:0];
               CSR_SMOOTHING: span_ff     <= csr_wdata[SPAN_W-1:0];
               CSR_INVERT:    invert_ff   <= csr_wdata[0];
               default: ;
            endcase
         end

         if (state_ff == ST_FILT) begin
            suppressed_ff <= 1'b0;
            if (mode_ff == MODE_SAMPLE) begin
               changed_ff   <= 1'b0;
               last_time_ff <= now_ff;
               seeded_ff    <= 1'b1;
               if (direct) begin
                  filter_ff <= sample_ff;
               end
            end
         end

         if (state_ff == ST_FWAIT && div_done) begin
            filter_ff <= neg_ff ? filter_ff - div_q[DATA_W-1:0]
                                : filter_ff + div_q[DATA_W-1:0];
         end

         if (state_ff == ST_GATE) begin
            if (suppress) begin
               suppressed_ff <= 1'b1;
            end else begin
               published_ff <= filter_ff;
            end
         end

         if (take_en) begin
            changed_ff <= take_chg;
            if (take_chg) begin
               has_out_ff <= 1'b1;
               level_ff   <= take_v;
               gen_ff     <= gen_ff + DATA_W'(1);
            end
         end

         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_tvalid && req_tready) begin
         mode_ff   <= req_tuser;
         sample_ff <= req_tdata[31:0];
         now_ff    <= req_tdata[63:32];
         forced_ff <= req_tdata[79:64];
      end

      if (state_ff == ST_FILT) begin
         neg_ff     <= diff[DATA_W];
         mag_ff     <= diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
         elapsed_ff <= elapsed[SPAN_W-1:0];
      end

      if (state_ff == ST_FMUL || state_ff == ST_NMUL) begin
         prod_ff <= mul_a * mul_b;
      end

      if (state_ff == ST_GATE) begin
         range_ff <= rng;
         p_ff     <= invert_ff ? rng - p_raw : p_raw;
      end

      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {5'b0, filter_ff, gen_ff, suppressed_ff, changed_ff,
                         has_out_ff, level_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[bench/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import scn_pkg::*;

   localparam int unsigned MAX_IDLE       = 18;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned SETTLE_CYCLES  = 70;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned PHASES         = 10;
   localparam int unsigned PHASE_ITEMS    = 90;
   localparam longint      I32_MIN        = -64'sd2147483648;
   localparam longint      I32_MAX        = 64'sd2147483647;

   typedef struct packed {
      logic [15:0] normalized;
      logic        value_valid;
      logic        changed;
      logic        suppressed;
      logic [31:0] generation;
      logic [31:0] filtered;
   } control_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // sample, time_ms, forced_value
   logic                  req_tuser  = 1'b0;  // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // normalized, value_valid, changed, suppressed, generation, filtered, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [DATA_W-1:0]     csr_wdata  = '0;

   // predictor copy of the registers and the control state
   longint      cfg_minimum;
   longint      cfg_maximum;
   bit [30:0]   cfg_deadband;
   bit [15:0]   cfg_smoothing;
   bit          cfg_invert;
   bit          f_seeded;
   longint      f_value;
   longint      pub_level;
   bit [31:0]   last_ms;
   bit          has_level;
   bit [15:0]   level;
   bit [31:0]   generation_count;

   control_result_type queued_outputs[$];

   // traffic shaping
   bit        sender_quiet   = 1'b0;
   bit        receiver_quiet = 1'b0;
   bit        hold_receiver  = 1'b0;
   longint    walk;
   longint    walk_lo;
   longint    walk_hi;
   longint    walk_step;
   bit [31:0] clock_ms;

   int error_count = 0;
   int idle_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   smoothed_control_normalizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic void restore_defaults();
      cfg_minimum      = 0;
      cfg_maximum      = 65536;
      cfg_deadband     = '0;
      cfg_smoothing    = '0;
      cfg_invert       = 1'b0;
      f_seeded         = 1'b0;
      f_value          = 0;
      pub_level        = 0;
      last_ms          = '0;
      has_level        = 1'b0;
      level            = '0;
      generation_count = '0;
      walk             = 0;
      walk_lo          = -64'sd65536;
      walk_hi          = 64'sd131072;
      walk_step        = 8192;
      clock_ms         = '0;
   endfunction

   function automatic longint clamp_i32(longint v);
      if (v < I32_MIN) return I32_MIN;
      if (v > I32_MAX) return I32_MAX;
      return v;
   endfunction

   // (diff * elapsed / span), rounded to nearest, ties away from zero
   function automatic longint filter_step(longint diff, longint elapsed, longint span);
      longint mag;
      longint q;
      mag = (diff < 0) ? -diff : diff;
      mag = mag * elapsed;
      q = (2 * mag + span) / (2 * span);
      return (diff < 0) ? -q : q;
   endfunction

   function automatic bit [15:0] position_of(longint lvl);
      longint span;
      longint p;
      span = cfg_maximum - cfg_minimum;
      if (span <= 0) begin
         span = 1;
         p = (lvl <= cfg_minimum) ? 0 : 1;
      end else if (lvl <= cfg_minimum) begin
         p = 0;
      end else if (lvl >= cfg_maximum) begin
         p = span;
      end else begin
         p = lvl - cfg_minimum;
      end
      if (cfg_invert) p = span - p;
      return 16'((2 * p * longint'(NORM_MAX) + span) / (2 * span));
   endfunction

   function automatic bit take_level(bit [15:0] v);
      if (!has_level || level != v) begin
         has_level = 1'b1;
         level = v;
         generation_count = generation_count + 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic control_result_type control_step(logic mode, logic [31:0] smp,
                                                       logic [31:0] now, logic [15:0] fv);
      control_result_type r;
      longint             s;
      longint             gap;
      bit [31:0]          elapsed;
      bit                 chg;
      bit                 sup;
      chg = 1'b0;
      sup = 1'b0;
      if (mode == MODE_FORCE) begin
         chg = take_level(fv);
      end else begin
         s = longint'($signed(smp));
         if (!f_seeded) begin
            f_value = s;
            f_seeded = 1'b1;
         end else if (cfg_smoothing != 0) begin
            elapsed = now - last_ms;
            if (elapsed == 0) elapsed = 1;
            if (elapsed >= {16'd0, cfg_smoothing})
               f_value = s;
            else
               f_value = f_value + filter_step(s - f_value, longint'({32'd0, elapsed}),
                                               longint'({48'd0, cfg_smoothing}));
         end else begin
            f_value = s;
         end
         last_ms = now;
         gap = f_value - pub_level;
         if (gap < 0) gap = -gap;
         if (has_level && cfg_deadband != 0 && gap < longint'({33'd0, cfg_deadband})) begin
            sup = 1'b1;
         end else begin
            pub_level = f_value;
            chg = take_level(position_of(f_value));
         end
      end
      r.normalized  = level;
      r.value_valid = has_level;
      r.changed     = chg;
      r.suppressed  = sup;
      r.generation  = generation_count;
      r.filtered    = f_value[31:0];
      return r;
   endfunction

   function automatic void check_field(string what, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         error_count++;
      end
   endfunction

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (addr)
         CSR_MINIMUM:   cfg_minimum = longint'($signed(data));
         CSR_MAXIMUM:   cfg_maximum = longint'($signed(data));
         CSR_DEADBAND:  cfg_deadband = data[30:0];
         CSR_SMOOTHING: cfg_smoothing = data[15:0];
         CSR_INVERT:    cfg_invert = data[0];
         default: ;
      endcase
   endtask

   // writes all five registers and recenters the random sample walk
   task automatic apply_settings(logic [31:0] lo, logic [31:0] hi, logic [31:0] db,
                                 logic [15:0] sm, logic inv);
      longint spread;
      write_reg(CSR_MINIMUM, lo);
      write_reg(CSR_MAXIMUM, hi);
      write_reg(CSR_DEADBAND, db);
      write_reg(CSR_SMOOTHING, {16'd0, sm});
      write_reg(CSR_INVERT, {31'd0, inv});
      spread = (cfg_maximum > cfg_minimum) ? cfg_maximum - cfg_minimum : 65536;
      walk_lo = clamp_i32(((cfg_minimum < cfg_maximum) ? cfg_minimum : cfg_maximum)
                          - spread / 4);
      walk_hi = clamp_i32(((cfg_minimum < cfg_maximum) ? cfg_maximum : cfg_minimum)
                          + spread / 4);
      walk = walk_lo / 2 + walk_hi / 2;
      walk_step = spread / 8 + 1;
   endtask

   task automatic send_item(logic mode, logic [31:0] smp, logic [31:0] now, logic [15:0] fv);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {fv, now, smp};
      do @(posedge clock); while (!req_tready);
      queued_outputs.push_back(control_step(mode, smp, now, fv));
   endtask

   // stop offering items, let every result come back and the sequencer go idle
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (queued_outputs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic        mode;
      logic [31:0] smp;
      logic [15:0] fv;
      longint      step;
      int          pick;
      mode = ($urandom_range(0, 99) < 15) ? MODE_FORCE : MODE_SAMPLE;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         smp = $urandom;
      end else begin
         step = longint'({32'd0, $urandom}) % (2 * walk_step + 1) - walk_step;
         walk = walk + step;
         if (walk < walk_lo) walk = walk_lo;
         if (walk > walk_hi) walk = walk_hi;
         smp = walk[31:0];
      end
      pick = $urandom_range(0, 99);
      if (pick < 5)
         clock_ms = $urandom;
      else if (pick >= 12)
         clock_ms = clock_ms + $urandom_range(0, 2 * cfg_smoothing + 4);
      // sometimes force the value already held, which must not count as a change
      fv = ($urandom_range(0, 4) == 0) ? level : 16'($urandom);
      send_item(mode, smp, clock_ms, fv);
   endtask

   // reset register values, seeding, equal and wrapping timestamps, force mode
   task automatic test_directed_defaults();
      send_item(MODE_SAMPLE, 32'h0000_8000, 32'h0000_0000, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0000_8000, 32'h0000_0000, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0000_0000, 32'h0000_0005, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0001_0000, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(MODE_SAMPLE, 32'h8000_0000, 32'h0000_0000, 16'h0000);
      send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0001, 16'h0000);
      send_item(MODE_FORCE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
      send_item(MODE_FORCE,  32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      send_item(MODE_FORCE,  32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      send_item(MODE_SAMPLE, 32'h0000_4000, 32'h0000_0002, 16'h0000);
   endtask

   task automatic test_filter_and_deadband();
      settle();
      apply_settings(32'hFFFF_0000, 32'h0003_0000, 32'h0000_4000, 16'd100, 1'b1);
      send_item(MODE_SAMPLE, 32'h0001_0000, 32'hFFFF_FFF0, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0002_0000, 32'h0000_0014, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0002_0000, 32'h0000_0014, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0002_1000, 32'h0000_0015, 16'h0000);
      send_item(MODE_SAMPLE, 32'hFFFD_0000, 32'h0000_0100, 16'h0000);
      // force sets a value but leaves the published level where it was
      send_item(MODE_FORCE,  32'h0000_0000, 32'h0000_0000, 16'h0100);
      send_item(MODE_SAMPLE, 32'hFFFD_0000, 32'h0000_0101, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0003_0000, 32'h0000_0102, 16'h0000);
   endtask

   task automatic test_degenerate_ranges();
      settle();
      apply_settings(32'h0000_5000, 32'h0000_5000, 32'h0, 16'd0, 1'b0);
      send_item(MODE_SAMPLE, 32'h0000_5000, 32'h0000_0010, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0000_5001, 32'h0000_0011, 16'h0000);
      send_item(MODE_SAMPLE, 32'h0000_4FFF, 32'h0000_0012, 16'h0000);
      settle();
      apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd0, 1'b1);
      send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0013, 16'h0000);
      send_item(MODE_SAMPLE, 32'h8000_0000, 32'h0000_0014, 16'h0000);
      settle();
      // widest span, widest deadband, longest smoothing time
      apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1);
      send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h0000_8000, 16'h0000);
      send_item(MODE_SAMPLE, 32'h8000_0000, 32'h0000_8000, 16'h0000);
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_output_backpressure();
      settle();
      apply_settings(32'h0000_0000, 32'h0010_0000, 32'h0000_0800, 16'd50, 1'b0);
      sender_quiet = 1'b1;
      hold_receiver = 1'b1;
      for (int i = 0; i < 30; i++) send_random_item();
      sender_quiet = 1'b0;
   endtask

   task automatic pick_random_settings(int phase);
      longint    lo;
      longint    hi;
      longint    span;
      longint    spread;
      longint    db;
      bit [15:0] sm;
      lo = longint'($signed($urandom)) >>> $urandom_range(0, 14);
      span = (longint'({32'd0, $urandom}) >> $urandom_range(0, 31)) + 1;
      hi = clamp_i32(lo + span);
      case (phase)
         0: begin
            lo = I32_MIN;
            hi = I32_MAX;
         end
         1: hi = lo;
         2: hi = clamp_i32(lo - span);
         default: ;
      endcase
      spread = (hi > lo) ? hi - lo : 65536;
      case ($urandom_range(0, 2))
         0: db = 0;
         1: db = longint'({32'd0, $urandom}) % (spread / 8 + 1);
         default: db = longint'({32'd0, $urandom}) % (spread / 64 + 1);
      endcase
      if (db > I32_MAX) db = I32_MAX;
      case ($urandom_range(0, 4))
         0: sm = 16'd0;
         1: sm = 16'd1;
         2: sm = 16'hFFFF;
         default: sm = 16'($urandom_range(2, 3000));
      endcase
      apply_settings(lo[31:0], hi[31:0], db[31:0], sm, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         pick_random_settings(ph);
         if ($urandom_range(0, 1) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
         sender_quiet   = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   initial begin
      restore_defaults();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_filter_and_deadband();
      test_degenerate_ranges();
      test_output_backpressure();
      test_random_traffic();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : result_receiver
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = receiver_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold_receiver) begin
            stall = HOLD_CYCLES;
            hold_receiver = 1'b0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      control_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (queued_outputs.size() == 0) begin
            $display("%0t ns: unexpected item, expected none, actual %0h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = queued_outputs.pop_front();
            check_field("normalized", want.normalized, rsp_tdata[15:0]);
            check_field("value_valid", want.value_valid, rsp_tdata[16]);
            check_field("changed", want.changed, rsp_tdata[17]);
            check_field("suppressed", want.suppressed, rsp_tdata[18]);
            check_field("generation", want.generation, rsp_tdata[50:19]);
            check_field("filtered", want.filtered, rsp_tdata[82:51]);
         end
      end
   end

   // counts cycles in which nothing moves on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
